// ===== hw/rtl/rpd_pkg.sv =====
`timescale 1ns / 1ps

package rpd_pkg;

  // Field widths
  localparam int TIME_W   = 32;
  localparam int PULSE_W  = 12;
  localparam int HALF_W   = 14;
  localparam int RAW_W    = 32;
  localparam int GROUP_W  = 16;
  localparam int SWITCH_W = 3;

  // Default code width
  localparam int CODE_BITS_DEF = 32;

  // Timing factors in pulse lengths
  localparam int SYNC_FACTOR = 30;
  localparam int LONG_FACTOR = 3;

  // Register reset values
  localparam logic [PULSE_W-1:0] PULSE_LENGTH_RST    = 12'd186;
  localparam logic [PULSE_W-1:0] PULSE_TOLERANCE_RST = 12'd74;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_PULSE_LENGTH    = 1'b0,
    CFG_PULSE_TOLERANCE = 1'b1
  } cfg_index_t;

  // Switch pair decoding
  localparam int SWITCH_BASE  = 4;
  localparam int SWITCH_PAIRS = 5;
  localparam logic [3:0] ON_NIBBLE = 4'h3;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Request from front to queue: one finished code
  typedef struct packed {
    logic             valid;
    logic [RAW_W-1:0] code;
  } code_req_t;

  // Lowest pair of code bits 4..13 with both bits set
  function automatic logic [SWITCH_W:0] decode_switch(input logic [RAW_W-1:0] code);
    logic [2*SWITCH_PAIRS-1:0] pairs;
    logic [SWITCH_W:0]         res;
    pairs = code[SWITCH_BASE +: 2*SWITCH_PAIRS];
    res   = '0;
    for (int k = SWITCH_PAIRS - 1; k >= 0; k--) begin
      if (pairs[2*k +: 2] == 2'b11) begin
        res = {1'b1, SWITCH_W'(k)};
      end
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/rpd_front.sv =====
`timescale 1ns / 1ps

module rpd_front #(
  parameter int CODE_BITS = rpd_pkg::CODE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  rpd_pkg::cfg_index_t         cfg_index,
  input  logic [rpd_pkg::PULSE_W-1:0] cfg_wdata,
  input  logic                        in_push,
  input  logic                        in_full,
  input  logic [rpd_pkg::TIME_W-1:0]  in_edge_time_us,
  output rpd_pkg::code_req_t          req
);

  localparam int TW  = rpd_pkg::TIME_W;
  localparam int PW  = rpd_pkg::PULSE_W;
  localparam int HW  = rpd_pkg::HALF_W;
  localparam int SW  = PW + 5;
  localparam int WW  = HW + 1;

  logic [PW-1:0]        pulse_len_r, pulse_tol_r;
  logic [TW-1:0]        prev_r, prev_nxt;
  logic [HW-1:0]        half_r, half_nxt;
  logic                 half_vld_r, half_vld_nxt;
  logic [CODE_BITS-1:0] sr_r, sr_nxt;
  logic                 coll_r, coll_nxt;

  logic          acc;
  logic [TW-1:0] gap;
  logic [SW-1:0] sync_thr;
  logic [HW-1:0] short_c, long_c;
  logic [WW-1:0] short_hi, long_hi;
  logic          is_sync, in_short, in_long;
  logic          bit_val;
  logic [63:0]   code_ext;

  assign acc = in_push & ~in_full;
  assign gap = in_edge_time_us - prev_r;

  // Classify the gap
  always_comb begin
    sync_thr = SW'(pulse_len_r) * SW'(rpd_pkg::SYNC_FACTOR);
    short_c  = HW'(pulse_len_r);
    long_c   = HW'(pulse_len_r) * HW'(rpd_pkg::LONG_FACTOR);
    short_hi = WW'(short_c) + WW'(pulse_tol_r);
    long_hi  = WW'(long_c) + WW'(pulse_tol_r);
    is_sync  = gap > TW'(sync_thr);
    in_short = (({1'b0, gap} + (TW+1)'(pulse_tol_r)) > (TW+1)'(short_c)) &&
               (gap < TW'(short_hi));
    in_long  = (({1'b0, gap} + (TW+1)'(pulse_tol_r)) > (TW+1)'(long_c)) &&
               (gap < TW'(long_hi));
    bit_val  = TW'(half_r) > gap;
  end

  // Advance the decode state
  always_comb begin
    prev_nxt     = prev_r;
    half_nxt     = half_r;
    half_vld_nxt = half_vld_r;
    sr_nxt       = sr_r;
    coll_nxt     = coll_r;
    if (acc) begin
      prev_nxt = in_edge_time_us;
      if (is_sync) begin
        sr_nxt   = '0;
        coll_nxt = 1'b1;
      end else if (coll_r) begin
        if (in_short || in_long) begin
          if (!half_vld_r) begin
            half_nxt     = gap[HW-1:0];
            half_vld_nxt = 1'b1;
          end else begin
            sr_nxt       = {sr_r[CODE_BITS-2:0], bit_val};
            half_nxt     = '0;
            half_vld_nxt = 1'b0;
          end
        end else begin
          sr_nxt       = '0;
          coll_nxt     = 1'b0;
          half_nxt     = '0;
          half_vld_nxt = 1'b0;
        end
      end
    end
  end

  // Emit a request for a finished nonzero code
  assign code_ext  = 64'(sr_r);
  assign req.valid = acc & is_sync & (sr_r != '0);
  assign req.code  = code_ext[rpd_pkg::RAW_W-1:0];

  // Hold state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_len_r <= rpd_pkg::PULSE_LENGTH_RST;
      pulse_tol_r <= rpd_pkg::PULSE_TOLERANCE_RST;
      prev_r      <= '0;
      half_r      <= '0;
      half_vld_r  <= 1'b0;
      sr_r        <= '0;
      coll_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rpd_pkg::CFG_PULSE_LENGTH:    pulse_len_r <= cfg_wdata;
          rpd_pkg::CFG_PULSE_TOLERANCE: pulse_tol_r <= cfg_wdata;
          default: ;
        endcase
      end
      prev_r     <= prev_nxt;
      half_r     <= half_nxt;
      half_vld_r <= half_vld_nxt;
      sr_r       <= sr_nxt;
      coll_r     <= coll_nxt;
    end
  end

endmodule

// ===== hw/rtl/rpd_queue.sv =====
`timescale 1ns / 1ps

module rpd_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rpd_pkg::code_req_t        req,
  output logic                      full,
  output logic                      empty,
  input  logic                      pop,
  output logic [rpd_pkg::RAW_W-1:0] code
);

  localparam int DEPTH = rpd_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [rpd_pkg::RAW_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]             wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]             cnt_r;
  logic                      do_wr, do_rd;

  assign full  = cnt_r == CW'(DEPTH);
  assign empty = cnt_r == '0;
  assign do_wr = req.valid & ~full;
  assign do_rd = pop & ~empty;
  assign code  = mem_r[rd_ptr_r];

  // Store incoming codes
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= req.code;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rpd_back.sv =====
`timescale 1ns / 1ps

module rpd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  logic [rpd_pkg::RAW_W-1:0]    q_code,
  output logic                         q_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [rpd_pkg::RAW_W-1:0]    out_raw_code,
  output logic [rpd_pkg::GROUP_W-1:0]  out_group_code,
  output logic [rpd_pkg::SWITCH_W-1:0] out_switch_index,
  output logic                         out_switch_found,
  output logic                         out_turn_on
);

  logic                         vld_r;
  logic [rpd_pkg::RAW_W-1:0]    raw_r;
  logic [rpd_pkg::GROUP_W-1:0]  group_r;
  logic [rpd_pkg::SWITCH_W-1:0] sw_idx_r;
  logic                         sw_found_r;
  logic                         on_r;
  logic [rpd_pkg::SWITCH_W:0]   sw_dec;
  logic                         take;

  assign take   = ~q_empty & (~vld_r | out_pop);
  assign q_pop  = take;
  assign sw_dec = rpd_pkg::decode_switch(q_code);

  // Hold the valid flag of the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (out_pop) begin
      vld_r <= 1'b0;
    end
  end

  // Load decoded fields
  always_ff @(posedge clk) begin
    if (take) begin
      raw_r      <= q_code;
      group_r    <= q_code[rpd_pkg::RAW_W-1 -: rpd_pkg::GROUP_W];
      sw_idx_r   <= sw_dec[rpd_pkg::SWITCH_W-1:0];
      sw_found_r <= sw_dec[rpd_pkg::SWITCH_W];
      on_r       <= q_code[3:0] == rpd_pkg::ON_NIBBLE;
    end
  end

  assign out_empty        = ~vld_r;
  assign out_raw_code     = raw_r;
  assign out_group_code   = group_r;
  assign out_switch_index = sw_idx_r;
  assign out_switch_found = sw_found_r;
  assign out_turn_on      = on_r;

endmodule

// ===== hw/rtl/rf_remote_pulse_decoder_core.sv =====
`timescale 1ns / 1ps
// Decoder for on-off keyed tri-state remote codes.
// Input channel: push one request per received signal edge with its
// microsecond timestamp on in_edge_time_us; it is taken when in_push is high
// and in_full is low. Edges are classified in the accepting cycle.
// Result channel: while out_empty is low the oldest decoded frame is on the
// out_ ports; out_pop takes it. A result appears only for a sync gap that
// follows a nonzero collected code.
// Path: the sync edge writes the code into the queue; the output register
// loads it from the queue once the register is empty or being popped.
// Throughput: one edge per cycle while in_full is low; the front classifies
// each taken edge combinationally into its registered state, and a two-entry
// queue plus the output register decouple it from the result side.
// Stall: if the result side does not pop, up to three frames are held; once
// the third is held in_full rises and stays high until a result is popped.
// Reset (rst_n low, synchronous): timing registers return to 186 / 74 us,
// the edge history and code clear, collecting stops, the queue and output empty.
// Configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 pulse length, 1 tolerance) at the clock edge; write only while idle.

module rf_remote_pulse_decoder_core #(
  parameter int CODE_BITS = rpd_pkg::CODE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  rpd_pkg::cfg_index_t          cfg_index,
  input  logic [rpd_pkg::PULSE_W-1:0]  cfg_wdata,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [rpd_pkg::TIME_W-1:0]   in_edge_time_us,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [rpd_pkg::RAW_W-1:0]    out_raw_code,
  output logic [rpd_pkg::GROUP_W-1:0]  out_group_code,
  output logic [rpd_pkg::SWITCH_W-1:0] out_switch_index,
  output logic                         out_switch_found,
  output logic                         out_turn_on
);

  rpd_pkg::code_req_t        req;
  logic                      q_empty;
  logic                      q_pop;
  logic [rpd_pkg::RAW_W-1:0] q_code;

  // Classify edges and collect code bits
  rpd_front #(
    .CODE_BITS(CODE_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_edge_time_us (in_edge_time_us),
    .req             (req)
  );

  // Buffer finished codes
  rpd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .full  (in_full),
    .empty (q_empty),
    .pop   (q_pop),
    .code  (q_code)
  );

  // Decode frames into result fields
  rpd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_code           (q_code),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_raw_code     (out_raw_code),
    .out_group_code   (out_group_code),
    .out_switch_index (out_switch_index),
    .out_switch_found (out_switch_found),
    .out_turn_on      (out_turn_on)
  );

endmodule

// ===== test/tb_rf_remote_pulse_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_rf_remote_pulse_decoder_core;

  typedef struct packed {
    logic [rpd_pkg::RAW_W-1:0]    raw_code;
    logic [rpd_pkg::GROUP_W-1:0]  group_code;
    logic [rpd_pkg::SWITCH_W-1:0] switch_index;
    logic                         switch_found;
    logic                         turn_on;
  } frame_t;

  // One queued edge request, or a marker that holds the sender until all frames are out
  typedef struct {
    bit                         stall;
    logic [rpd_pkg::TIME_W-1:0] stamp;
  } edge_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  rpd_pkg::cfg_index_t cfg_index = rpd_pkg::CFG_PULSE_LENGTH;
  logic [rpd_pkg::PULSE_W-1:0] cfg_wdata = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic [rpd_pkg::TIME_W-1:0] in_edge_time_us = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [rpd_pkg::RAW_W-1:0] out_raw_code;
  logic [rpd_pkg::GROUP_W-1:0] out_group_code;
  logic [rpd_pkg::SWITCH_W-1:0] out_switch_index;
  logic out_switch_found;
  logic out_turn_on;

  rf_remote_pulse_decoder_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_edge_time_us  (in_edge_time_us),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_raw_code     (out_raw_code),
    .out_group_code   (out_group_code),
    .out_switch_index (out_switch_index),
    .out_switch_found (out_switch_found),
    .out_turn_on      (out_turn_on)
  );

  always #4 clk = ~clk;

  // Decoder shadow state and timing settings
  int                         pulse_len = rpd_pkg::PULSE_LENGTH_RST;
  int                         pulse_tol = rpd_pkg::PULSE_TOLERANCE_RST;
  logic [rpd_pkg::TIME_W-1:0] last_stamp = '0;
  logic [rpd_pkg::HALF_W-1:0] half_len = '0;
  bit                         half_valid = 1'b0;
  logic [rpd_pkg::RAW_W-1:0]  shift_code = '0;
  bit                         collecting = 1'b0;

  frame_t    frames_due[$];
  edge_req_t edge_q[$];
  logic [rpd_pkg::TIME_W-1:0] gen_stamp = '0;
  int  queued_edges = 0;
  int  mismatches = 0;
  bit  edge_taken = 1'b0;
  bit  drain_hold = 1'b0;
  int  send_wait = 0;
  int  send_calm = 0;
  int  pop_wait = 0;
  int  pop_calm = 0;

  function automatic frame_t describe_code(logic [rpd_pkg::RAW_W-1:0] code);
    frame_t f;
    logic [2*rpd_pkg::SWITCH_PAIRS-1:0] pairs;
    f.raw_code     = code;
    f.group_code   = code[31:16];
    f.switch_index = '0;
    f.switch_found = 1'b0;
    f.turn_on      = (code[3:0] == rpd_pkg::ON_NIBBLE);
    pairs = code[13:4];
    // lowest pair with both bits set wins
    for (int k = 0; k < rpd_pkg::SWITCH_PAIRS; k++) begin
      if (!f.switch_found && (&pairs[2*k +: 2])) begin
        f.switch_index = k[rpd_pkg::SWITCH_W-1:0];
        f.switch_found = 1'b1;
      end
    end
    return f;
  endfunction

  function automatic bit near(longint g, longint centre);
    return (g > centre - pulse_tol) && (g < centre + pulse_tol);
  endfunction

  // Advance the shadow decoder by one accepted edge
  task automatic track_edge(input logic [rpd_pkg::TIME_W-1:0] stamp);
    logic [rpd_pkg::TIME_W-1:0] gap;
    longint g;
    gap = stamp - last_stamp;
    g = gap;
    if (g > longint'(rpd_pkg::SYNC_FACTOR) * pulse_len) begin
      if (shift_code != '0) frames_due.push_back(describe_code(shift_code));
      shift_code = '0;
      collecting = 1'b1;
    end else if (collecting) begin
      if (near(g, pulse_len) || near(g, rpd_pkg::LONG_FACTOR * pulse_len)) begin
        if (!half_valid) begin
          half_len   = gap[rpd_pkg::HALF_W-1:0];
          half_valid = 1'b1;
        end else begin
          shift_code = {shift_code[rpd_pkg::RAW_W-2:0], ({18'b0, half_len} > gap)};
          half_len   = '0;
          half_valid = 1'b0;
        end
      end else begin
        shift_code = '0;
        collecting = 1'b0;
        half_len   = '0;
        half_valid = 1'b0;
      end
    end
    last_stamp = stamp;
  endtask

  function automatic int pick_idle(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 149) == 0) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 70);
  endfunction

  // Sender: take requests at the rising edge, drive the next one at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      track_edge(in_edge_time_us);
      edge_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : driver
    edge_req_t req;
    if (rst_n && !(in_push && !edge_taken)) begin
      edge_taken = 1'b0;
      if (send_wait > 0) begin
        send_wait--;
        in_push <= 1'b0;
        in_edge_time_us <= $urandom;
      end else if (drain_hold) begin
        if (frames_due.size() == 0) drain_hold = 1'b0;
        in_push <= 1'b0;
      end else if (edge_q.size() != 0) begin
        req = edge_q.pop_front();
        if (req.stall) begin
          drain_hold = 1'b1;
          in_push <= 1'b0;
        end else begin
          in_push <= 1'b1;
          in_edge_time_us <= req.stamp;
          send_wait = pick_idle(send_calm);
        end
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Receiver: pop with random stalls
  always @(negedge clk) begin
    if (rst_n) begin
      if (pop_wait > 0) begin
        pop_wait--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        pop_wait = pick_idle(pop_calm);
      end
    end
  end

  // Compare each popped frame against the oldest predicted one
  always @(posedge clk) begin : monitor
    frame_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (frames_due.size() == 0) begin
        $error("unexpected frame, raw_code %h", out_raw_code);
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        if (out_raw_code !== want.raw_code) begin
          $error("raw_code expected %h got %h", want.raw_code, out_raw_code);
          mismatches++;
        end
        if (out_group_code !== want.group_code) begin
          $error("group_code expected %h got %h", want.group_code, out_group_code);
          mismatches++;
        end
        if (out_switch_index !== want.switch_index) begin
          $error("switch_index expected %0d got %0d", want.switch_index, out_switch_index);
          mismatches++;
        end
        if (out_switch_found !== want.switch_found) begin
          $error("switch_found expected %b got %b", want.switch_found, out_switch_found);
          mismatches++;
        end
        if (out_turn_on !== want.turn_on) begin
          $error("turn_on expected %b got %b", want.turn_on, out_turn_on);
          mismatches++;
        end
      end
    end
  end

  task automatic push_abs(input logic [rpd_pkg::TIME_W-1:0] stamp);
    gen_stamp = stamp;
    edge_q.push_back('{1'b0, gen_stamp});
    queued_edges++;
  endtask

  task automatic push_gap(input int unsigned gap);
    push_abs(gen_stamp + gap);
  endtask

  // Random gap strictly inside the window around centre
  function automatic int unsigned win_gap(int centre);
    int lo;
    int hi;
    lo = centre - pulse_tol + 1;
    hi = centre + pulse_tol - 1;
    if (lo < 0) lo = 0;
    if (hi < lo) return centre;
    return $urandom_range(lo, hi);
  endfunction

  // Gaps at the window and sync boundaries, or a random gap
  function automatic int unsigned edge_gap();
    case ($urandom_range(0, 4))
      0: return rpd_pkg::SYNC_FACTOR * pulse_len;
      1: return pulse_len + pulse_tol;
      2: return rpd_pkg::LONG_FACTOR * pulse_len + pulse_tol;
      3: return (pulse_len > pulse_tol) ? pulse_len - pulse_tol : 0;
      default: return $urandom_range(0, 40 * pulse_len);
    endcase
  endfunction

  task automatic push_sync();
    if ($urandom_range(0, 7) == 0)
      push_gap($urandom_range(rpd_pkg::SYNC_FACTOR * pulse_len + 1, 32'hFFFF_FFFF));
    else
      push_gap(rpd_pkg::SYNC_FACTOR * pulse_len + 1 + $urandom_range(0, 2 * pulse_len));
  endtask

  // Random gap in either the short or the long window
  function automatic int unsigned any_half();
    return win_gap($urandom_range(0, 1) ? rpd_pkg::LONG_FACTOR * pulse_len : pulse_len);
  endfunction

  task automatic push_bit(input bit one);
    if ($urandom_range(0, 4) == 0) begin
      push_gap(any_half());
      push_gap(any_half());
    end else if (one) begin
      push_gap(win_gap(rpd_pkg::LONG_FACTOR * pulse_len));
      push_gap(win_gap(pulse_len));
    end else begin
      push_gap(win_gap(pulse_len));
      push_gap(win_gap(rpd_pkg::LONG_FACTOR * pulse_len));
    end
  endtask

  // Sync followed by a code, sent most significant bit first
  task automatic push_frame();
    int nbits;
    logic [63:0] bits;
    push_sync();
    nbits = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
    bits = {$urandom, $urandom};
    if ($urandom_range(0, 6) == 0) bits[13:4] = 10'b11 << (2 * $urandom_range(0, 4));
    if ($urandom_range(0, 4) == 0) bits[3:0] = rpd_pkg::ON_NIBBLE;
    for (int i = nbits - 1; i >= 0; i--) begin
      push_bit(bits[i]);
      if ($urandom_range(0, 99) == 0) push_gap(edge_gap());
    end
    // leave a half bit dangling into the next sync
    if ($urandom_range(0, 5) == 0)
      push_gap(any_half());
  endtask

  task automatic random_edges(input int budget);
    int start;
    int r;
    start = queued_edges;
    while (queued_edges - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 75) push_frame();
      else if (r < 83) push_abs($urandom);
      else if (r < 88) push_abs(32'hFFFF_FFFF - $urandom_range(0, 20000));
      else if (r < 96) push_gap($urandom_range(0, 40 * pulse_len));
      else push_gap(edge_gap());
      if ($urandom_range(0, 49) == 0) edge_q.push_back('{1'b1, '0});
    end
  endtask

  task automatic drain();
    while (edge_q.size() != 0 || in_push || drain_hold || frames_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timing(input int len, input int tol);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= rpd_pkg::CFG_PULSE_LENGTH;
    cfg_wdata <= len[rpd_pkg::PULSE_W-1:0];
    @(negedge clk);
    cfg_index <= rpd_pkg::CFG_PULSE_TOLERANCE;
    cfg_wdata <= tol[rpd_pkg::PULSE_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    pulse_len = len;
    pulse_tol = tol;
  endtask

  task automatic run_phase(input int len, input int tol, input int budget);
    set_timing(len, tol);
    random_edges(budget);
    drain();
  endtask

  initial begin : stimulus
    int rl;
    int rt;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: idle zero gap, wrapped sync with empty code
    push_abs('0);
    push_abs(32'hFFFF_FFFF);
    // code 0011: on nibble, no switch pair
    push_gap(pulse_len);
    push_gap(rpd_pkg::LONG_FACTOR * pulse_len);
    push_gap(pulse_len);
    push_gap(rpd_pkg::LONG_FACTOR * pulse_len);
    push_gap(rpd_pkg::LONG_FACTOR * pulse_len);
    push_gap(pulse_len);
    push_gap(rpd_pkg::LONG_FACTOR * pulse_len);
    push_gap(pulse_len);
    push_gap(rpd_pkg::SYNC_FACTOR * pulse_len + 1);
    // half bit carried across a sync
    push_gap(rpd_pkg::LONG_FACTOR * pulse_len);
    push_gap(32'hFFFF_0000);
    push_gap(pulse_len);
    push_gap(rpd_pkg::SYNC_FACTOR * pulse_len + 1);
    // abort on the lower window bound, then idle gaps up to the sync limit
    push_gap(pulse_len - pulse_tol);
    push_gap(pulse_len + pulse_tol);
    push_gap(rpd_pkg::SYNC_FACTOR * pulse_len);
    push_gap(rpd_pkg::SYNC_FACTOR * pulse_len + 1);
    // window edges just inside, then abort on the upper bound
    push_gap(pulse_len + pulse_tol - 1);
    push_gap(pulse_len - pulse_tol + 1);
    push_gap(rpd_pkg::LONG_FACTOR * pulse_len + pulse_tol);
    edge_q.push_back('{1'b1, '0});
    push_abs(32'hFFFF_FFFF);
    random_edges(450);
    drain();

    run_phase(4095, 4095, 110);
    run_phase(1, 0, 60);
    run_phase(1, 1, 110);
    run_phase(1, 4095, 110);
    run_phase(50, 60, 110);
    run_phase(300, 200, 110);
    run_phase(4095, 0, 60);
    rl = $urandom_range(2, 800);
    rt = $urandom_range(0, rl + 50);
    run_phase(rl, rt, 110);
    run_phase(rpd_pkg::PULSE_LENGTH_RST, rpd_pkg::PULSE_TOLERANCE_RST, 110);

    repeat (6) @(posedge clk);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
